// ===== hdl/bdac_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Request and result payload types, ASCII codes and request type codes.
// No dependencies.
package bdac_pkg;

	localparam int unsigned MaxValueWidth = 64;

	// request type codes
	localparam logic REQ_SIGNED   = 1'b0;
	localparam logic REQ_UNSIGNED = 1'b1;

	// character codes
	localparam logic [6:0] ASCII_ZERO  = 7'd48;
	localparam logic [6:0] ASCII_NINE  = 7'd57;
	localparam logic [6:0] ASCII_MINUS = 7'd45;

	typedef struct packed {
		logic                     req_type;
		logic [MaxValueWidth-1:0] value;
	} in_req_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last_char;
	} out_res_t;

endpackage

// ===== hdl/bdac_fifo.sv =====
// Small register queue used between the converter stages and at the output.
// Generic width and depth; no package dependency.
module bdac_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/bdac_front.sv =====
// Front end: takes requests, splits sign from magnitude, queues the work.
// Depends on bdac_pkg and bdac_fifo.
module bdac_front
	import bdac_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  in_req_t              req,
	input  logic                 q_pop,
	output logic                 q_empty,
	output logic                 q_neg,
	output logic [VALUE_WIDTH-1:0] q_mag
);

	logic [VALUE_WIDTH-1:0] raw;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic [VALUE_WIDTH:0]   q_word;

	// bits above VALUE_WIDTH are dropped; most negative value negates to itself
	assign raw = req.value[VALUE_WIDTH-1:0];
	assign neg = (req.req_type == REQ_SIGNED) && raw[VALUE_WIDTH-1];
	assign mag = neg ? (~raw + VALUE_WIDTH'(1)) : raw;

	bdac_fifo #(
		.WIDTH(VALUE_WIDTH + 1),
		.DEPTH(2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data({neg, mag}),
		.full   (full),
		.rd_en  (q_pop),
		.rd_data(q_word),
		.empty  (q_empty)
	);

	assign q_neg = q_word[VALUE_WIDTH];
	assign q_mag = q_word[VALUE_WIDTH-1:0];

endmodule

// ===== hdl/bdac_back.sv =====
// Back end: shift-and-add-3 BCD conversion, one bit a cycle, then one
// character or skipped leading zero a cycle into the result queue while it is not full. Depends on bdac_pkg.
module bdac_back
	import bdac_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  logic                   q_neg,
	input  logic [VALUE_WIDTH-1:0] q_mag,
	output logic                   q_pop,
	input  logic                   out_full,
	output logic                   out_push,
	output out_res_t               out_data
);

	// decimal digits of 2^VALUE_WIDTH, log10(2) ~ 0.30103
	localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned BW   = 4 * NDIG;
	localparam int unsigned CW   = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned RW   = $clog2(NDIG + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CONV   = 4'b0010,
		ST_SIGN   = 4'b0100,
		ST_DIGITS = 4'b1000
	} back_state_t;

	back_state_t            state_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BW-1:0]          bcd_q;
	logic                   neg_q;
	logic [CW-1:0]          cnt_q;
	logic [RW-1:0]          rem_q;
	logic                   started_q;

	logic [BW-1:0] bcd_adj;
	logic [3:0]    top_digit;
	logic          skip;
	logic          emit;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	assign top_digit = bcd_q[BW-1 -: 4];
	// leading zero, never the last digit
	assign skip = (state_q == ST_DIGITS) && !started_q && (top_digit == 4'd0)
		&& (rem_q != RW'(1));
	assign emit = ((state_q == ST_DIGITS) && !skip && !out_full)
		|| ((state_q == ST_SIGN) && !out_full);

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_push = emit;

	always_comb begin
		if (state_q == ST_SIGN) begin
			out_data.char_code = ASCII_MINUS;
			out_data.last_char = 1'b0;
		end else begin
			out_data.char_code = ASCII_ZERO + {3'b000, top_digit};
			out_data.last_char = (rem_q == RW'(1));
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				bin_q <= q_mag;
				bcd_q <= '0;
				neg_q <= q_neg;
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BW-2:0], bin_q[VALUE_WIDTH-1]};
				bin_q <= bin_q << 1;
			end
			ST_SIGN: begin
			end
			ST_DIGITS: begin
				if (skip || emit) begin
					bcd_q <= {bcd_q[BW-5:0], 4'b0000};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cnt_q   <= CW'(VALUE_WIDTH);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						rem_q     <= RW'(NDIG);
						started_q <= 1'b0;
						state_q   <= neg_q ? ST_SIGN : ST_DIGITS;
					end
				end
				ST_SIGN: begin
					if (emit) begin
						state_q <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (skip) begin
						rem_q <= rem_q - RW'(1);
					end else if (emit) begin
						rem_q     <= rem_q - RW'(1);
						started_q <= 1'b1;
						if (rem_q == RW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on bdac_pkg, bdac_front, bdac_back and bdac_fifo.
//
//  channel   direction  handshake            payload
//  request   in         push / full          req : in_req_t  (req_type, value)
//  result    out        pop / empty          res : out_res_t (char_code, last_char)
//
// In the back end an item passes through the idle state, the bit-serial BCD
// shift, a minus sign step for a negative value and one step per digit slot
// (NDIG = decimal digits of 2^VALUE_WIDTH, 20 at 64 bits); the shift is the
// bulk of it, and every digit slot, leading zero or not, takes its own step.
// arst_n clears all queues and the sequencer at once; no clearing pass.
// The two-entry request queue keeps taking requests while the back end works;
// a full result queue stalls the character step, and full rises only once
// both request entries wait behind it.
module binary_to_decimal_ascii
	import bdac_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_req_t  req,
	output logic     empty,
	input  logic     pop,
	output out_res_t res
);

	// front to back work queue
	logic                   q_pop;
	logic                   q_empty;
	logic                   q_neg;
	logic [VALUE_WIDTH-1:0] q_mag;

	// back end to result queue
	logic     out_full;
	logic     out_push;
	out_res_t out_data;

	// sign split and request queue
	bdac_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.q_pop  (q_pop),
		.q_empty(q_empty),
		.q_neg  (q_neg),
		.q_mag  (q_mag)
	);

	// conversion and character sequencing
	bdac_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_neg   (q_neg),
		.q_mag   (q_mag),
		.q_pop   (q_pop),
		.out_full(out_full),
		.out_push(out_push),
		.out_data(out_data)
	);

	// result queue: the oldest character sits on res while empty is low
	bdac_fifo #(
		.WIDTH($bits(out_res_t)),
		.DEPTH(2)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_push),
		.wr_data(out_data),
		.full   (out_full),
		.rd_en  (pop),
		.rd_data(res),
		.empty  (empty)
	);

endmodule

// ===== hdl/bdac_checker.sv =====
// Port-level checks for binary_to_decimal_ascii, bound to the top level.
// Depends on bdac_pkg.
module bdac_checker
	import bdac_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     push,
	input logic     full,
	input logic     empty,
	input logic     pop,
	input out_res_t res
);

	// a waiting result holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(res))
		else $error("result changed while waiting");

	// only a minus sign or a digit comes out
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (res.char_code == ASCII_MINUS)
			|| ((res.char_code >= ASCII_ZERO) && (res.char_code <= ASCII_NINE)))
		else $error("bad character code");

	// a minus sign always has digits after it
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (res.char_code == ASCII_MINUS) |-> !res.last_char)
		else $error("minus sign marked last");

	// the request queue only fills on a taken request
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose with no request offered");

endmodule

bind binary_to_decimal_ascii bdac_checker u_bdac_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.res   (res)
);

// ===== sim/tb_binary_to_decimal_ascii.sv =====
// Self-checking testbench for binary_to_decimal_ascii: directed table, then random requests.
// Expected characters come from the table text or an in-bench decimal formatter and are checked in order.
// Depends on bdac_pkg and binary_to_decimal_ascii (hdl/).
module tb_binary_to_decimal_ascii;
	import bdac_pkg::*;

	localparam int unsigned VW          = 64;   // converter width under test
	localparam int          MAX_CHARS   = 20;   // '-' + 19 digits, or 20 unsigned digits
	localparam int          RAND_PER_PH = 26;   // random requests per idling phase
	localparam int          HOLD_CYCLES = 1500; // receiver hold-off in the back-pressure phase
	localparam int          TAIL_CYCLES = 200;  // quiet time after the last character
	localparam int          WDOG_LIMIT  = 8000; // cycles with no transfer before giving up

	logic     clk;
	logic     arst_n;
	logic     push;
	logic     full;
	in_req_t  req;
	logic     empty;
	logic     pop;
	out_res_t res;

	binary_to_decimal_ascii #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.req   (req),
		.empty (empty),
		.pop   (pop),
		.res   (res)
	);

	// directed rows; an empty text means "work it out with the formatter"
	typedef struct {
		logic        kind;
		logic [63:0] value;
		string       text;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		'{REQ_SIGNED,   64'd0,                      "0"},
		'{REQ_UNSIGNED, 64'd0,                      "0"},
		'{REQ_SIGNED,   64'd1,                      "1"},
		'{REQ_UNSIGNED, 64'd9,                      "9"},
		'{REQ_UNSIGNED, 64'd10,                     "10"},
		'{REQ_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF,    "-1"},
		'{REQ_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF,    "18446744073709551615"},
		'{REQ_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF,    "9223372036854775807"},
		'{REQ_SIGNED,   64'h8000_0000_0000_0000,    "-9223372036854775808"},
		'{REQ_UNSIGNED, 64'h8000_0000_0000_0000,    "9223372036854775808"},
		'{REQ_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF,    "9223372036854775807"},
		'{REQ_SIGNED,   64'hFFFF_FFFF_FFFF_FFF6,    "-10"},
		'{REQ_UNSIGNED, 64'd10000000000000000000,   "10000000000000000000"},
		'{REQ_UNSIGNED, 64'd9999999999999999999,    "9999999999999999999"},
		'{REQ_SIGNED,   64'h8000_0000_0000_0001,    "-9223372036854775807"},
		'{REQ_SIGNED,   64'h0123_4567_89AB_CDEF,    ""},
		'{REQ_UNSIGNED, 64'hFEDC_BA98_7654_3210,    ""},
		'{REQ_SIGNED,   64'hA5A5_A5A5_A5A5_A5A5,    ""},
		'{REQ_UNSIGNED, 64'h5A5A_5A5A_5A5A_5A5A,    ""},
		'{REQ_SIGNED,   64'd1234567890,             ""},
		'{REQ_SIGNED,   64'hFFFF_FFFF_B669_FD2E,    ""}
	};

	// characters still owed by the block, oldest first
	out_res_t char_q [$];

	// idling knobs, percent of cycles
	int idle_pct;
	int stall_pct;
	int hold_left;

	// bookkeeping
	int fails;
	int mismatches;
	int reqs_sent;
	int neg_reqs;
	int chars_seen;
	int full_stalls;
	int quiet_cycles;

	//------------------------------------------------------------------
	// clock
	//------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	//------------------------------------------------------------------
	// expected-character builders
	//------------------------------------------------------------------

	// decimal text of one request, most significant digit first
	function automatic void format_decimal(input in_req_t r);
		logic [VW-1:0] raw;
		logic [VW-1:0] mag;
		logic          neg;
		logic [3:0]    digs [MAX_CHARS];
		int            n;
		raw = r.value[VW-1:0];
		neg = (r.req_type == REQ_SIGNED) && raw[VW-1];
		// two's complement negate; the most negative value maps onto itself,
		// which read unsigned is exactly its magnitude
		mag = neg ? (~raw + 1'b1) : raw;
		n = 0;
		do begin
			digs[n] = 4'(mag % 10);
			mag     = mag / 10;
			n++;
		end while (mag != 0 && n < MAX_CHARS);
		if (neg)
			char_q.push_back('{char_code: ASCII_MINUS, last_char: 1'b0});
		for (int k = n - 1; k >= 0; k--)
			char_q.push_back('{char_code: ASCII_ZERO + 7'(digs[k]), last_char: (k == 0)});
	endfunction

	// text typed into the table, queued verbatim
	function automatic void queue_text(input string s);
		byte ch;
		for (int i = 0; i < s.len(); i++) begin
			ch = s[i];
			char_q.push_back('{char_code: ch[6:0], last_char: (i == s.len() - 1)});
		end
	endfunction

	//------------------------------------------------------------------
	// random requests: spread over every digit count and both signs
	//------------------------------------------------------------------
	function automatic in_req_t rand_req();
		in_req_t     r;
		logic [63:0] v;
		int          k;
		r.req_type = ($urandom_range(0, 1) == 0) ? REQ_SIGNED : REQ_UNSIGNED;
		case ($urandom_range(0, 9))
			0, 1: begin
				v = 64'($urandom_range(0, 999));
			end
			2: begin
				// small negative numbers
				v = -64'($urandom_range(0, 99999));
			end
			3: begin
				// either side of a power of ten, where the digit count changes
				k = $urandom_range(0, 19);
				v = 64'd1;
				repeat (k) v = v * 10;
				if ($urandom_range(0, 1) == 1)
					v = v - 1;
			end
			4, 5: begin
				v = {$urandom(), $urandom()};
			end
			default: begin
				v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
			end
		endcase
		r.value = v;
		return r;
	endfunction

	//------------------------------------------------------------------
	// request side: optional idle gap, then hold push until taken.
	// push only changes once per edge, so back-to-back requests keep it high.
	//------------------------------------------------------------------
	task automatic offer(input in_req_t r, input string text);
		while ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req  <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
		// request was taken at the first edge with push high; the loop only waits out full
		if (text.len() != 0)
			queue_text(text);
		else
			format_decimal(r);
		reqs_sent++;
		if (r.req_type == REQ_SIGNED && r.value[VW-1])
			neg_reqs++;
	endtask

	//------------------------------------------------------------------
	// result side: random stalls, plus a long hold-off when asked
	//------------------------------------------------------------------
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	//------------------------------------------------------------------
	// character checker: each popped character against the oldest owed one
	//------------------------------------------------------------------
	always @(posedge clk) begin
		out_res_t exp_chr;
		if (arst_n && pop && !empty) begin
			chars_seen++;
			if (char_q.size() == 0) begin
				fails++;
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected character: code %0d last %0b",
						$realtime, res.char_code, res.last_char);
			end else begin
				exp_chr = char_q.pop_front();
				if (res.char_code !== exp_chr.char_code ||
						res.last_char !== exp_chr.last_char) begin
					fails++;
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] char mismatch: code exp %0d got %0d, last exp %0b got %0b",
							$realtime, exp_chr.char_code, res.char_code,
							exp_chr.last_char, res.last_char);
				end
			end
		end
	end

	//------------------------------------------------------------------
	// input stall count and watchdog on transfers of either kind
	//------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && full)
				full_stalls++;
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d characters owed",
					quiet_cycles, char_q.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	//------------------------------------------------------------------
	// main sequence
	//------------------------------------------------------------------
	initial begin
		in_req_t r;
		fails        = 0;
		mismatches   = 0;
		reqs_sent    = 0;
		neg_reqs     = 0;
		chars_seen   = 0;
		full_stalls  = 0;
		quiet_cycles = 0;
		hold_left    = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		arst_n <= 1'b0;
		push   <= 1'b0;
		req    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, flat out
		foreach (dir_rows[i]) begin
			r.req_type = dir_rows[i].kind;
			r.value    = dir_rows[i].value;
			offer(r, dir_rows[i].text);
		end

		// random phases: none, idle sender, stalling receiver, light both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 10; stall_pct = 10; end
			endcase
			repeat (RAND_PER_PH)
				offer(rand_req(), "");
		end

		// back-pressure: receiver holds off while requests with the top bit set keep coming,
		// so the result queue fills and full must rise
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = HOLD_CYCLES;
		while (hold_left > 0) begin
			r = rand_req();
			r.value[VW-1] = 1'b1;
			offer(r, "");
		end
		push <= 1'b0;

		// drain, then watch for stray characters
		while (char_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("converted %0d requests (%0d negative signed), checked %0d characters",
			reqs_sent, neg_reqs, chars_seen);
		$display("input held back by full for %0d cycles; %0d mismatches",
			full_stalls, mismatches);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bdac_pkg.sv
hdl/bdac_fifo.sv
hdl/bdac_front.sv
hdl/bdac_back.sv
hdl/binary_to_decimal_ascii.sv
hdl/bdac_checker.sv
sim/tb_binary_to_decimal_ascii.sv
